FILE: hdl/mqd_pkg.sv
// ----------------------------------------------------------------------------
// mqd_pkg
// Shared types and constants for the MQTT fixed header deframer
// ----------------------------------------------------------------------------
package mqd_pkg;

    typedef enum logic [1:0]
    {
        PH_TYPE,
        PH_LENGTH,
        PH_BODY
    } phase_t;

    localparam logic [3:0] T_CONNACK = 4'd2;
    localparam logic [3:0] T_PUBLISH = 4'd3;
    localparam logic [3:0] T_PUBACK  = 4'd4;
    localparam logic [3:0] T_SUBACK  = 4'd9;

    localparam logic [2:0] ROLE_TYPE       = 3'd0;
    localparam logic [2:0] ROLE_LENGTH     = 3'd1;
    localparam logic [2:0] ROLE_TOPIC_LEN  = 3'd2;
    localparam logic [2:0] ROLE_TOPIC      = 3'd3;
    localparam logic [2:0] ROLE_IDENT      = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD    = 3'd5;
    localparam logic [2:0] ROLE_OTHER_BODY = 3'd6;

    localparam logic [15:0] TOPIC_LIMIT_RESET = 16'd128;
    localparam logic [16:0] OFFSET_MAX        = 17'h1FFFF;
    localparam int          LEN_BYTES_MAX     = 4;

    typedef struct packed
    {
        logic [7:0]  out_byte;
        logic [2:0]  byte_role;
        logic [3:0]  packet_type;
        logic [3:0]  packet_flags;
        logic [15:0] packet_ident;
        logic [15:0] topic_length;
        logic [27:0] body_length;
        logic        end_of_packet;
        logic        malformed;
    } mqd_result_t;

endpackage

FILE: hdl/mqd_step.sv
// ----------------------------------------------------------------------------
// mqd_step
// Per-byte deframing state and the combinational result of one byte
// ----------------------------------------------------------------------------
module mqd_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic [15:0]          topic_limit,
    output mqd_pkg::mqd_result_t res
);
    import mqd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [27:0] accum_reg, accum_next;
    logic [2:0]  len_cnt_reg, len_cnt_next;
    logic [27:0] left_reg, left_next;
    logic [16:0] offset_reg, offset_next;
    logic [3:0]  type_reg, type_next;
    logic [3:0]  flags_reg, flags_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] ident_reg, ident_next;
    logic        bad_mark_reg, bad_mark_next;

    logic        finish;
    logic        forced_bad;
    logic        to_body;
    logic        qos;
    logic        qos_next;
    logic [27:0] group_val;
    logic [16:0] tl_plus2;
    logic [16:0] tl_plus3;
    logic [17:0] need;
    logic        bad;

    assign qos      = flags_reg[2:1] != 2'b00;
    assign qos_next = flags_next[2:1] != 2'b00;
    assign tl_plus2 = {1'b0, tlen_reg} + 17'd2;
    assign tl_plus3 = {1'b0, tlen_reg} + 17'd3;

    always_comb
    begin
        case (len_cnt_reg[1:0])
            2'd0:    group_val = {21'b0, in_byte[6:0]};
            2'd1:    group_val = {14'b0, in_byte[6:0], 7'b0};
            2'd2:    group_val = {7'b0, in_byte[6:0], 14'b0};
            default: group_val = {in_byte[6:0], 21'b0};
        endcase
    end

    // datapath and result fields
    always_comb
    begin
        accum_next    = accum_reg;
        len_cnt_next  = len_cnt_reg;
        left_next     = left_reg;
        offset_next   = offset_reg;
        type_next     = type_reg;
        flags_next    = flags_reg;
        tlen_next     = tlen_reg;
        ident_next    = ident_reg;
        bad_mark_next = bad_mark_reg;
        finish        = 1'b0;
        forced_bad    = 1'b0;
        to_body       = 1'b0;
        res           = '0;
        res.out_byte  = in_byte;

        unique case (phase_reg)
            PH_LENGTH:
            begin
                res.byte_role = ROLE_LENGTH;
                if (bad_mark_reg)
                begin
                    finish     = 1'b1;
                    forced_bad = 1'b1;
                end
                else
                begin
                    accum_next   = accum_reg + group_val;
                    len_cnt_next = len_cnt_reg + 3'd1;
                    if (!in_byte[7])
                    begin
                        left_next = accum_next;
                        if (accum_next == 28'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            to_body = 1'b1;
                        end
                    end
                    else if (len_cnt_next >= 3'(LEN_BYTES_MAX))
                    begin
                        bad_mark_next = 1'b1;
                    end
                end
            end
            PH_BODY:
            begin
                if (type_reg == T_PUBLISH)
                begin
                    if (offset_reg == 17'd0)
                    begin
                        tlen_next     = {in_byte, 8'h00};
                        res.byte_role = ROLE_TOPIC_LEN;
                    end
                    else if (offset_reg == 17'd1)
                    begin
                        tlen_next     = {tlen_reg[15:8], in_byte};
                        res.byte_role = ROLE_TOPIC_LEN;
                    end
                    else if (offset_reg < tl_plus2)
                    begin
                        res.byte_role = ROLE_TOPIC;
                    end
                    else if (qos && offset_reg == tl_plus2)
                    begin
                        ident_next    = {in_byte, 8'h00};
                        res.byte_role = ROLE_IDENT;
                    end
                    else if (qos && offset_reg == tl_plus3)
                    begin
                        ident_next    = {ident_reg[15:8], in_byte};
                        res.byte_role = ROLE_IDENT;
                    end
                    else
                    begin
                        res.byte_role = ROLE_PAYLOAD;
                    end
                end
                else if (type_reg == T_PUBACK || type_reg == T_SUBACK)
                begin
                    if (offset_reg == 17'd0)
                    begin
                        ident_next    = {in_byte, 8'h00};
                        res.byte_role = ROLE_IDENT;
                    end
                    else if (offset_reg == 17'd1)
                    begin
                        ident_next    = {ident_reg[15:8], in_byte};
                        res.byte_role = ROLE_IDENT;
                    end
                    else
                    begin
                        res.byte_role = ROLE_PAYLOAD;
                    end
                end
                else
                begin
                    res.byte_role = ROLE_OTHER_BODY;
                end
                if (offset_reg != OFFSET_MAX)
                begin
                    offset_next = offset_reg + 17'd1;
                end
                if (left_reg != 28'd0)
                begin
                    left_next = left_reg - 28'd1;
                end
                finish = left_next == 28'd0;
            end
            default:
            begin
                res.byte_role = ROLE_TYPE;
                type_next     = in_byte[7:4];
                flags_next    = in_byte[3:0];
                accum_next    = '0;
                len_cnt_next  = '0;
                left_next     = '0;
                offset_next   = '0;
                tlen_next     = '0;
                ident_next    = '0;
                bad_mark_next = 1'b0;
            end
        endcase

        res.packet_type  = type_next;
        res.packet_flags = flags_next;
        res.body_length  = accum_next;

        // end of packet checks
        need = {2'b00, tlen_next} + 18'd2 + (qos_next ? 18'd2 : 18'd0);
        bad  = forced_bad;
        if (finish)
        begin
            res.end_of_packet = 1'b1;
            if (!forced_bad && type_next == T_PUBLISH)
            begin
                if (accum_next < {10'b0, need} || tlen_next >= topic_limit)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    res.topic_length = tlen_next;
                    res.packet_ident = qos_next ? ident_next : 16'd0;
                end
            end
            else if (!forced_bad && (type_next == T_PUBACK || type_next == T_SUBACK))
            begin
                res.packet_ident = (accum_next >= 28'd2) ? ident_next : 16'd0;
            end
            res.malformed = bad;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    if (finish)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else if (to_body)
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (finish)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = PH_LENGTH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TYPE;
            accum_reg    <= '0;
            len_cnt_reg  <= '0;
            left_reg     <= '0;
            offset_reg   <= '0;
            type_reg     <= '0;
            flags_reg    <= '0;
            tlen_reg     <= '0;
            ident_reg    <= '0;
            bad_mark_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (accept)
            begin
                accum_reg    <= accum_next;
                len_cnt_reg  <= len_cnt_next;
                left_reg     <= left_next;
                offset_reg   <= offset_next;
                type_reg     <= type_next;
                flags_reg    <= flags_next;
                tlen_reg     <= tlen_next;
                ident_reg    <= ident_next;
                bad_mark_reg <= bad_mark_next;
            end
        end
    end

    a_end_to_type: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.end_of_packet) |=> (phase_reg == PH_TYPE))
        else $error("packet end did not return to type byte");

    a_type_to_len: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_TYPE) |=> (phase_reg == PH_LENGTH && accum_reg == 28'd0))
        else $error("type byte did not start a fresh length");

    // mark stays set past the fifth length byte until the next type byte
    a_bad_mark_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        bad_mark_reg |-> (len_cnt_reg == 3'(LEN_BYTES_MAX) && phase_reg != PH_BODY))
        else $error("overflow mark without four length bytes");

    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (left_reg != 28'd0))
        else $error("body phase with no bytes left");

endmodule

FILE: hdl/mqd_out_reg.sv
// ----------------------------------------------------------------------------
// mqd_out_reg
// Result register with valid flag between step logic and output stream
// ----------------------------------------------------------------------------
module mqd_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  mqd_pkg::mqd_result_t res_in,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 can_load,
    output mqd_pkg::mqd_result_t res_out
);
    import mqd_pkg::*;

    logic        valid_reg, valid_next;
    mqd_result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

FILE: hdl/mqtt_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// mqtt_packet_deframer_core
// MQTT 3.1.1 fixed header deframer: tags each received byte with its role
//
//   channel  dir  handshake             payload
//   s_axis   in   tvalid / tready       received byte
//   m_axis   out  tvalid / tready       tagged byte, tlast on final byte
//   cfg      in   cfg_wr_en             topic length limit
//
// one byte per cycle while m_axis does not stall; each accepted byte loads the result register
// the per-byte state update and the result register set the rate
// a stalled result is held while s_axis_tready stays low
// reset is asynchronous, active low; topic limit resets to 128
// ----------------------------------------------------------------------------
module mqtt_packet_deframer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // out_byte, packet_type, packet_flags, packet_ident,
                                        // topic_length, body_length, malformed, zero fill
    output logic [2:0]  m_axis_tuser,   // byte_role
    output logic        m_axis_tlast,   // end_of_packet
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data     // topic_limit
);
    import mqd_pkg::*;

    logic [15:0] topic_limit_reg;
    logic        accept;
    logic        can_load;
    mqd_result_t step_res;
    mqd_result_t out_res;

    assign accept        = s_axis_tvalid && can_load;
    assign s_axis_tready = can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topic_limit_reg <= TOPIC_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            topic_limit_reg <= cfg_wr_data;
        end
    end

    mqd_step u_step
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_axis_tdata),
        .topic_limit (topic_limit_reg),
        .res         (step_res)
    );

    mqd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (step_res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .can_load  (can_load),
        .res_out   (out_res)
    );

    assign m_axis_tdata = {3'b000,
                           out_res.malformed,
                           out_res.body_length,
                           out_res.topic_length,
                           out_res.packet_ident,
                           out_res.packet_flags,
                           out_res.packet_type,
                           out_res.out_byte};
    assign m_axis_tuser = out_res.byte_role;
    assign m_axis_tlast = out_res.end_of_packet;

endmodule

FILE: bench/mqtt_packet_deframer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqtt_packet_deframer_core_tb
// Self-checking bench for the MQTT fixed header deframer
//
// Streams a short table of hand-built packets, then randomly generated packet
// streams (well-formed packets, truncated bodies, padded length fields, long
// bodies and length overflow) through the core. A behavioral model of the
// deframer predicts every output beat, and the output stream is compared
// field by field. The topic limit changes between phases while the core is
// idle. Source and sink throttle at random in all but the last phase.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer_core_tb;

    import mqd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_BEATS = 170;

    typedef struct packed
    {
        logic [7:0] data;
        logic       typed;
        logic [2:0] role;
        logic       eop;
        logic       bad;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    // deframer model state
    phase_t      frame_phase = PH_TYPE;
    logic [27:0] len_acc = '0;
    logic [2:0]  len_cnt = '0;
    logic [27:0] bytes_left = '0;
    logic [16:0] body_off = '0;
    logic [3:0]  pkt_type = '0;
    logic [3:0]  pkt_flags = '0;
    logic [15:0] pkt_tlen = '0;
    logic [15:0] pkt_ident = '0;
    logic        len_overflow = 1'b0;
    logic [15:0] topic_limit_q = TOPIC_LIMIT_RESET;

    mqd_result_t expected_beats [$];
    logic [7:0]  stream_q [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    stim_row_t directed_rows [26] = '{
        '{8'h30, 1'b1, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h00, 1'b1, ROLE_LENGTH, 1'b1, 1'b1},
        '{8'h20, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h01, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h00, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h40, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h02, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'hFF, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'hFF, 1'b1, ROLE_IDENT,  1'b1, 1'b0},
        '{8'h32, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h07, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h00, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h01, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h61, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h12, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h34, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'hAB, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'hCD, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'hF0, 1'b1, ROLE_TYPE,   1'b0, 1'b0},
        '{8'hFF, 1'b1, ROLE_LENGTH, 1'b0, 1'b0},
        '{8'hFF, 1'b1, ROLE_LENGTH, 1'b0, 1'b0},
        '{8'hFF, 1'b1, ROLE_LENGTH, 1'b0, 1'b0},
        '{8'hFF, 1'b1, ROLE_LENGTH, 1'b0, 1'b0},
        '{8'h7F, 1'b1, ROLE_LENGTH, 1'b1, 1'b1},
        '{8'h9F, 1'b0, ROLE_TYPE,   1'b0, 1'b0},
        '{8'h00, 1'b1, ROLE_LENGTH, 1'b1, 1'b0}
    };

    mqtt_packet_deframer_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // end-of-packet fields: identifier, topic length and malformed decision
    function automatic void close_packet(input logic forced, inout mqd_result_t r);
        logic        bad;
        logic        qos;
        int unsigned need;
        bad  = forced;
        qos  = |pkt_flags[2:1];
        need = 2 + pkt_tlen + (qos ? 2 : 0);
        if (!bad && pkt_type == T_PUBLISH)
        begin
            if (len_acc < 2 || len_acc < need || pkt_tlen >= topic_limit_q)
                bad = 1'b1;
            else
            begin
                r.topic_length = pkt_tlen;
                r.packet_ident = qos ? pkt_ident : 16'h0000;
            end
        end
        else if (!bad && (pkt_type == T_PUBACK || pkt_type == T_SUBACK))
        begin
            r.packet_ident = (len_acc >= 2) ? pkt_ident : 16'h0000;
        end
        r.end_of_packet = 1'b1;
        r.malformed     = bad;
        frame_phase     = PH_TYPE;
    endfunction

    function automatic logic [2:0] body_role(input logic [7:0] b);
        int unsigned off;
        int unsigned tl;
        logic        qos;
        off = body_off;
        tl  = pkt_tlen;
        qos = |pkt_flags[2:1];
        if (pkt_type == T_PUBLISH)
        begin
            if (off == 0)
            begin
                pkt_tlen = {b, 8'h00};
                return ROLE_TOPIC_LEN;
            end
            if (off == 1)
            begin
                pkt_tlen[7:0] = b;
                return ROLE_TOPIC_LEN;
            end
            if (off < 2 + tl)
                return ROLE_TOPIC;
            if (qos && off == 2 + tl)
            begin
                pkt_ident = {b, 8'h00};
                return ROLE_IDENT;
            end
            if (qos && off == 3 + tl)
            begin
                pkt_ident[7:0] = b;
                return ROLE_IDENT;
            end
            return ROLE_PAYLOAD;
        end
        if (pkt_type == T_PUBACK || pkt_type == T_SUBACK)
        begin
            if (off == 0)
            begin
                pkt_ident = {b, 8'h00};
                return ROLE_IDENT;
            end
            if (off == 1)
            begin
                pkt_ident[7:0] = b;
                return ROLE_IDENT;
            end
            return ROLE_PAYLOAD;
        end
        return ROLE_OTHER_BODY;
    endfunction

    task automatic predict_beat(input logic [7:0] b, output mqd_result_t r);
        int unsigned shift;
        r = '0;
        r.out_byte = b;
        case (frame_phase)
            PH_LENGTH:
            begin
                r.byte_role = ROLE_LENGTH;
                if (len_overflow)
                begin
                    r.body_length = len_acc;
                    close_packet(1'b1, r);
                end
                else
                begin
                    shift   = 7 * len_cnt[1:0];
                    len_acc = len_acc + (28'(b[6:0]) << shift);
                    len_cnt = len_cnt + 3'd1;
                    r.body_length = len_acc;
                    if (!b[7])
                    begin
                        bytes_left = len_acc;
                        if (bytes_left == 0)
                            close_packet(1'b0, r);
                        else
                            frame_phase = PH_BODY;
                    end
                    else if (len_cnt >= LEN_BYTES_MAX)
                    begin
                        len_overflow = 1'b1;
                    end
                end
            end
            PH_BODY:
            begin
                r.byte_role = body_role(b);
                if (body_off != OFFSET_MAX)
                    body_off = body_off + 17'd1;
                if (bytes_left != 0)
                    bytes_left = bytes_left - 28'd1;
                r.body_length = len_acc;
                if (bytes_left == 0)
                    close_packet(1'b0, r);
            end
            default:
            begin
                r.byte_role  = ROLE_TYPE;
                pkt_type     = b[7:4];
                pkt_flags    = b[3:0];
                len_acc      = '0;
                len_cnt      = '0;
                bytes_left   = '0;
                body_off     = '0;
                pkt_tlen     = '0;
                pkt_ident    = '0;
                len_overflow = 1'b0;
                frame_phase  = PH_LENGTH;
            end
        endcase
        r.packet_type  = pkt_type;
        r.packet_flags = pkt_flags;
    endtask

    // one random packet appended to the byte stream
    task automatic queue_packet();
        logic [3:0]  ptype;
        logic [3:0]  flags;
        logic [15:0] tlen;
        logic [7:0]  len_bytes [4];
        int unsigned nlen;
        int unsigned body;
        int unsigned rem;
        int unsigned pick;
        int unsigned pad;
        pick  = $urandom_range(0, 18);
        flags = 4'($urandom);
        tlen  = 16'($urandom_range(0, 6));
        body  = $urandom_range(0, 5);
        ptype = 4'($urandom);
        if (pick < 9)
        begin
            ptype = T_PUBLISH;
            if ($urandom_range(0, 7) == 0)
                tlen = 16'($urandom);
            else if (topic_limit_q <= 16 && $urandom_range(0, 2) == 0)
                tlen = topic_limit_q - 16'($urandom_range(0, 1));
            body = 2 + tlen + (|flags[2:1] ? 2 : 0) + $urandom_range(0, 4);
            if (tlen > 16)
                body = $urandom_range(0, 12);
            else if ($urandom_range(0, 5) == 0)
                body = $urandom_range(0, body);
        end
        else if (pick < 13)
        begin
            ptype = $urandom_range(0, 1) ? T_PUBACK : T_SUBACK;
        end
        else if (pick < 15)
        begin
            ptype = T_CONNACK;
            body  = $urandom_range(0, 3);
        end
        else if (pick == 17)
        begin
            // four continuation bytes then a fifth length byte
            stream_q.push_back({ptype, flags});
            repeat (4) stream_q.push_back({1'b1, 7'($urandom)});
            stream_q.push_back(8'($urandom));
            return;
        end
        else if (pick == 18)
        begin
            body = $urandom_range(128, 300);
        end
        stream_q.push_back({ptype, flags});
        rem  = body;
        nlen = 0;
        do
        begin
            len_bytes[nlen] = {1'b0, 7'(rem)};
            rem = rem >> 7;
            if (rem != 0)
                len_bytes[nlen][7] = 1'b1;
            nlen++;
        end
        while (rem != 0);
        // non-minimal length encoding padded with zero groups
        if (nlen < 4 && $urandom_range(0, 7) == 0)
        begin
            pad = $urandom_range(1, 4 - nlen);
            repeat (pad)
            begin
                len_bytes[nlen - 1][7] = 1'b1;
                len_bytes[nlen] = 8'h00;
                nlen++;
            end
        end
        for (int i = 0; i < nlen; i++)
            stream_q.push_back(len_bytes[i]);
        for (int i = 0; i < body; i++)
        begin
            if (pick < 9 && i == 0)
                stream_q.push_back(tlen[15:8]);
            else if (pick < 9 && i == 1)
                stream_q.push_back(tlen[7:0]);
            else
                stream_q.push_back(8'($urandom));
        end
    endtask

    task automatic send_beat(input stim_row_t row);
        mqd_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.data;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        predict_beat(row.data, r);
        if (row.typed)
        begin
            r.byte_role     = row.role;
            r.end_of_packet = row.eop;
            r.malformed     = row.bad;
        end
        expected_beats.push_back(r);
    endtask

    task automatic hold_off();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_topic_limit(input logic [15:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        topic_limit_q = limit;
    endtask

    function automatic void check_field(input string name, input logic [27:0] want,
                                        input logic [27:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        mqd_result_t e;
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("output beat with no beat pending: tdata 0x%0h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                e = expected_beats.pop_front();
                check_field("out_byte", e.out_byte, m_axis_tdata[7:0]);
                check_field("packet_type", e.packet_type, m_axis_tdata[11:8]);
                check_field("packet_flags", e.packet_flags, m_axis_tdata[15:12]);
                check_field("packet_ident", e.packet_ident, m_axis_tdata[31:16]);
                check_field("topic_length", e.topic_length, m_axis_tdata[47:32]);
                check_field("body_length", e.body_length, m_axis_tdata[75:48]);
                check_field("malformed", e.malformed, m_axis_tdata[76]);
                check_field("byte_role", e.byte_role, m_axis_tuser);
                check_field("end_of_packet", e.end_of_packet, m_axis_tlast);
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]  b;
        int unsigned sent;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 51;
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        for (int p = 0; p < 3; p++)
        begin
            hold_off();
            case (p)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 51;
                    write_topic_limit(16'd1);
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 35;
                    write_topic_limit(16'hFFFF);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_topic_limit(16'($urandom_range(2, 12)));
                end
            endcase
            while (stream_q.size() < PHASE_BEATS)
                queue_packet();
            sent = 0;
            while (stream_q.size() != 0)
            begin
                b = stream_q.pop_front();
                send_beat('{b, 1'b0, ROLE_TYPE, 1'b0, 1'b0});
                sent++;
                // source holds off mid-stream until the sink has caught up
                if (p == 0 && sent == 80)
                    hold_off();
            end
        end

        hold_off();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
